[rtl/core/rsv_pkg.sv]
package rsv_pkg;

    localparam int AREA_W  = 18;
    localparam int COUNT_W = 15;
    localparam int TEXT_W  = 8;
    localparam int PHASE_W = 3;

    localparam logic [AREA_W-1:0] WORD_BYTES      = AREA_W'(4);
    localparam logic [AREA_W-1:0] MIN_CHUNK_BYTES = AREA_W'(8);

    localparam logic [PHASE_W-1:0] PH_HEADER = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SSRC   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TYPE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TEXT   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PAD    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd6;

    localparam logic [1:0] HDR_LEN_HI = 2'd2;
    localparam logic [1:0] HDR_LEN_LO = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               packet_valid;
        logic [COUNT_W-1:0] chunk_count;
    } out_item_t;

endpackage

[rtl/core/rsv_parser.sv]
module rsv_parser
    import rsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         hdr_idx_reg, hdr_idx_next;
    logic [AREA_W-1:0]  area_reg, area_next;
    logic [AREA_W-1:0]  consumed_reg, consumed_next;
    logic [AREA_W-1:0]  offset_reg, offset_next;
    logic [AREA_W-1:0]  chunk_rem_reg, chunk_rem_next;
    logic [TEXT_W-1:0]  text_reg, text_next;
    logic [COUNT_W-1:0] chunks_reg, chunks_next;
    logic               err_reg, err_next;

    logic               start_chunk;
    logic               end_chunk;
    logic [AREA_W-1:0]  rem;
    logic [AREA_W:0]    item_end;
    logic [AREA_W:0]    len_end;
    logic [7:0]         b;
    logic               pkt_ok;

    assign b = item.data_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        area_next      = area_reg;
        consumed_next  = consumed_reg;
        offset_next    = offset_reg;
        chunk_rem_next = chunk_rem_reg;
        text_next      = text_reg;
        chunks_next    = chunks_reg;
        err_next       = err_reg;
        start_chunk    = 1'b0;
        end_chunk      = 1'b0;
        rem            = '0;
        // item bounds use the offset before this byte
        item_end       = {1'b0, offset_reg} + (AREA_W+1)'(2);
        len_end        = {1'b0, offset_reg} + (AREA_W+1)'(1) + (AREA_W+1)'(b);

        if (phase_reg == PH_HEADER)
        begin
            hdr_idx_next = hdr_idx_reg + 2'd1;
            if (hdr_idx_reg == HDR_LEN_HI)
            begin
                area_next = {2'b00, b, 8'h00};
            end
            else if (hdr_idx_reg == HDR_LEN_LO)
            begin
                area_next     = {area_reg[15:8], b, 2'b00};
                consumed_next = '0;
                start_chunk   = 1'b1;
            end
        end
        else if (phase_reg < PH_DONE)
        begin
            consumed_next = consumed_reg + AREA_W'(1);
            offset_next   = offset_reg + AREA_W'(1);
            case (phase_reg)
                PH_SSRC:
                begin
                    if (offset_next >= WORD_BYTES)
                        phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (b == 8'h00)
                    begin
                        if (offset_next[1:0] == 2'b00)
                            end_chunk = 1'b1;
                        else
                            phase_next = PH_PAD;
                    end
                    else if (item_end > {1'b0, chunk_rem_reg})
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (len_end >= {1'b0, chunk_rem_reg})
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else if (b == 8'h00)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        text_next  = b;
                        phase_next = PH_TEXT;
                    end
                end
                PH_TEXT:
                begin
                    text_next = text_reg - TEXT_W'(1);
                    if (text_next == '0)
                        phase_next = PH_TYPE;
                end
                PH_PAD:
                begin
                    if (offset_next[1:0] == 2'b00)
                        end_chunk = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (end_chunk)
        begin
            if (offset_next > chunk_rem_reg)
            begin
                err_next   = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                chunks_next = chunks_reg + COUNT_W'(1);
                start_chunk = 1'b1;
            end
        end

        // open the next chunk, finish when the area is used up, or flag an error if less than a minimum chunk remains
        if (start_chunk)
        begin
            rem = area_next - consumed_next;
            if (consumed_next >= area_next)
            begin
                phase_next = PH_DONE;
            end
            else if (rem < MIN_CHUNK_BYTES)
            begin
                err_next   = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                chunk_rem_next = rem;
                offset_next    = '0;
                phase_next     = PH_SSRC;
            end
        end
    end

    assign pkt_ok              = !err_next && (phase_next == PH_DONE);
    assign result.packet_valid = pkt_ok;
    assign result.chunk_count  = pkt_ok ? chunks_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            area_reg      <= '0;
            consumed_reg  <= '0;
            offset_reg    <= '0;
            chunk_rem_reg <= '0;
            text_reg      <= '0;
            chunks_reg    <= '0;
            err_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                phase_reg     <= PH_HEADER;
                hdr_idx_reg   <= '0;
                area_reg      <= '0;
                consumed_reg  <= '0;
                offset_reg    <= '0;
                chunk_rem_reg <= '0;
                text_reg      <= '0;
                chunks_reg    <= '0;
                err_reg       <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                hdr_idx_reg   <= hdr_idx_next;
                area_reg      <= area_next;
                consumed_reg  <= consumed_next;
                offset_reg    <= offset_next;
                chunk_rem_reg <= chunk_rem_next;
                text_reg      <= text_next;
                chunks_reg    <= chunks_next;
                err_reg       <= err_next;
            end
        end
    end

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> phase_reg == PH_DONE)
        else $error("error flag set outside done phase");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> phase_reg == PH_HEADER && hdr_idx_reg == 2'd0
                                   && chunks_reg == '0)
        else $error("state not cleared after last byte");

    a_text_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TEXT |-> text_reg != '0)
        else $error("text phase with no bytes left");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> !err_reg && chunks_reg == '0)
        else $error("header phase carries stale chunk state");

endmodule

[rtl/core/rtcp_sdes_packet_validator.sv]
// result_valid rises once the last byte has been transferred into the input register and its parser step
// has loaded the result register
// throughput: one byte per cycle; a last byte stalls only while the previous result is not taken
// reset: rst_n asynchronously clears both valid flags and the parser state
module rtcp_sdes_packet_validator
    import rsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_item_t  byte_data,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_data
);

    logic      hold_valid_reg;
    in_item_t  hold_reg;
    logic      res_valid_reg;
    out_item_t res_reg;
    out_item_t parsed;
    logic      advance;

    // a last byte waits only when the result slot is still occupied
    assign advance    = hold_valid_reg &&
                        (!hold_reg.last_byte || !res_valid_reg || result_ready);
    assign byte_ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (byte_ready)
            hold_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            hold_reg <= byte_data;
    end

    rsv_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (hold_reg),
        .result (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && hold_reg.last_byte)
            res_valid_reg <= 1'b1;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && hold_reg.last_byte)
            res_reg <= parsed;
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.packet_valid |-> res_reg.chunk_count == '0)
        else $error("invalid packet reports chunks");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result_ready |-> !(advance && hold_reg.last_byte))
        else $error("pending result overwritten");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !advance |=> hold_valid_reg && $stable(hold_reg))
        else $error("held byte lost while stalled");

endmodule
